FILE: hw/rtl/fc_pkg.sv
// Shared types, command codes and constants for the FIR convolution block.
// Used by every module under hw/rtl; depends on nothing else.
package fc_pkg;

	localparam int OUT_WIDTH        = 37;
	localparam int CMD_W            = 2;
	localparam int IDX_W            = 5;
	localparam int CFG_W            = 6;
	localparam int APB_DW           = 32;
	localparam int APB_AW           = 3;
	localparam int DEF_MAX_TAPS     = 32;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam logic [CFG_W-1:0] TAP_COUNT_RESET = 6'd32;

	typedef enum logic [0:0] {
		REG_TAP_COUNT = 1'b0,
		REG_NONE      = 1'b1
	} reg_index_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_END    = 2'd2,
		CMD_NONE   = 2'd3
	} command_t;

	typedef logic signed [OUT_WIDTH-1:0] acc_t;

	typedef struct packed {
		logic valid;
		logic last;
	} op_ctl_t;

	// smallest g with g*g >= n: products per first-level adder lane
	function automatic int group_size(input int n);
		int g;
		begin
			g = 1;
			while (g * g < n) g = g + 1;
			return g;
		end
	endfunction

endpackage

FILE: hw/rtl/fir_convolution.sv
// Top level of the streaming fixed-point FIR convolution block.
// Depends on fc_pkg, fc_regs, fc_front and fc_sum.
//
// Input channel (item_valid/item_ready) carries one word: command, coef_index
// and value. A load word writes one coefficient and yields nothing. A sample
// word shifts the delay line and yields one result with last_of_run set. An
// end word yields min(tap_count, MAX_TAPS)-1 tail results, the final one
// marked, then clears the delay line; tap_count 0 or 1 yields none.
// Output channel (result_valid/result_ready) carries filtered_value (Q6.30)
// and last_of_run.
// Pipeline: an accepted word is registered in the product register, then in
// the adder lane register and then in the output register, which presents
// the result.
// Throughput: one sample word per cycle while the output is not stalled. An
// end word holds item_ready low while the tail sequencer issues one zero
// shift per cycle, unless stalled, for each tail result.
// Stalls: when result_ready is low the output holds; earlier stages keep
// filling until full, then item_ready drops.
// Reset: delay line and coefficients clear to zero, tap_count returns to 32,
// nothing is in flight. Tap count is written over the APB port at address 0;
// the user must write it only while the block is idle; the block does not enforce this.
module fir_convolution #(
	parameter int MAX_TAPS     = fc_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_WIDTH = fc_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fc_pkg::APB_AW-1:0]           paddr,
	input  logic [fc_pkg::APB_DW-1:0]           pwdata,
	output logic [fc_pkg::APB_DW-1:0]           prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [fc_pkg::CMD_W-1:0]            command,
	input  logic [fc_pkg::IDX_W-1:0]            coef_index,
	input  logic signed [SAMPLE_WIDTH-1:0]      value,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [fc_pkg::OUT_WIDTH-1:0] filtered_value,
	output logic                                last_of_run
);

	logic [fc_pkg::CFG_W-1:0]          tap_count;
	fc_pkg::op_ctl_t                   ctl_s1;
	logic signed [2*SAMPLE_WIDTH-1:0]  prod_s1 [MAX_TAPS];
	logic                              s2_free;

	fc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tap_count (tap_count)
	);

	fc_front #(
		.MAX_TAPS     (MAX_TAPS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.command    (command),
		.coef_index (coef_index),
		.value      (value),
		.tap_count  (tap_count),
		.s2_free    (s2_free),
		.ctl_s1     (ctl_s1),
		.prod_s1    (prod_s1)
	);

	fc_sum #(
		.MAX_TAPS     (MAX_TAPS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_sum (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_s1         (ctl_s1),
		.prod_s1        (prod_s1),
		.s2_free        (s2_free),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.filtered_value (filtered_value),
		.last_of_run    (last_of_run)
	);

endmodule

FILE: hw/rtl/fc_regs.sv
// APB-style register port holding the tap count.
// Depends on fc_pkg.
module fc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fc_pkg::APB_AW-1:0]     paddr,
	input  logic [fc_pkg::APB_DW-1:0]     pwdata,
	output logic [fc_pkg::APB_DW-1:0]     prdata,
	output logic                          pready,
	output logic [fc_pkg::CFG_W-1:0]      tap_count
);

	fc_pkg::reg_index_t          sel;
	logic [fc_pkg::CFG_W-1:0]    tap_count_q;

	assign sel       = fc_pkg::reg_index_t'(paddr[fc_pkg::APB_AW-1]);
	assign pready    = 1'b1;
	assign tap_count = tap_count_q;

	always_comb begin
		unique case (sel)
			fc_pkg::REG_TAP_COUNT: prdata = fc_pkg::APB_DW'(tap_count_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fc_pkg::TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && sel == fc_pkg::REG_TAP_COUNT) begin
			tap_count_q <= pwdata[fc_pkg::CFG_W-1:0];
		end
	end

endmodule

FILE: hw/rtl/fc_front.sv
// Word decode, tail sequencer, delay line, coefficient store and tap products.
// Depends on fc_pkg; feeds fc_sum through the first pipeline register.
module fc_front #(
	parameter int MAX_TAPS     = fc_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_WIDTH = fc_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [fc_pkg::CMD_W-1:0]          command,
	input  logic [fc_pkg::IDX_W-1:0]          coef_index,
	input  logic signed [SAMPLE_WIDTH-1:0]    value,
	input  logic [fc_pkg::CFG_W-1:0]          tap_count,
	input  logic                              s2_free,
	output fc_pkg::op_ctl_t                   ctl_s1,
	output logic signed [2*SAMPLE_WIDTH-1:0]  prod_s1 [MAX_TAPS]
);

	localparam int PW    = 2 * SAMPLE_WIDTH;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);

	logic signed [SAMPLE_WIDTH-1:0] dl_q    [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] coef_q  [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] dl_next [MAX_TAPS];
	logic signed [PW-1:0]           prod_n  [MAX_TAPS];
	logic [CNT_W-1:0]               tail_cnt_q;
	logic [CNT_W-1:0]               tail_n;
	fc_pkg::command_t               cmd;
	logic                           adv, take, tail_busy, tail_last;
	logic                           issue_sample, issue_tail, dl_empty;
	logic signed [SAMPLE_WIDTH-1:0] shift_in;

	assign cmd          = fc_pkg::command_t'(command);
	assign tail_busy    = tail_cnt_q != '0;
	assign tail_last    = tail_cnt_q == CNT_W'(1);
	assign adv          = !ctl_s1.valid || s2_free;
	assign item_ready   = adv && !tail_busy;
	assign take         = item_valid && item_ready;
	assign issue_sample = take && cmd == fc_pkg::CMD_SAMPLE;
	assign issue_tail   = tail_busy && adv;
	assign shift_in     = issue_sample ? value : '0;

	always_comb begin
		tail_n = '0;
		if (tap_count > fc_pkg::CFG_W'(1)) begin
			if (int'(tap_count) > MAX_TAPS)
				tail_n = CNT_W'(MAX_TAPS - 1);
			else
				tail_n = CNT_W'(tap_count - 1'b1);
		end
	end

	always_comb begin
		dl_next[0] = shift_in;
		for (int k = 1; k < MAX_TAPS; k++) dl_next[k] = dl_q[k-1];
	end

	always_comb begin
		for (int k = 0; k < MAX_TAPS; k++) begin
			if (k == 0 || int'(tap_count) > k)
				prod_n[k] = coef_q[k] * dl_next[k];
			else
				prod_n[k] = '0;
		end
	end

	always_comb begin
		dl_empty = 1'b1;
		for (int k = 0; k < MAX_TAPS; k++) if (dl_q[k] != '0) dl_empty = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1     <= '0;
			tail_cnt_q <= '0;
			for (int k = 0; k < MAX_TAPS; k++) begin
				dl_q[k]   <= '0;
				coef_q[k] <= '0;
			end
		end else begin
			if (adv) begin
				ctl_s1.valid <= issue_sample || issue_tail;
				ctl_s1.last  <= issue_sample || tail_last;
			end
			if (take && cmd == fc_pkg::CMD_END)
				tail_cnt_q <= tail_n;
			else if (issue_tail)
				tail_cnt_q <= tail_cnt_q - 1'b1;
			if (issue_sample || (issue_tail && !tail_last)) begin
				dl_q <= dl_next;
			end else if ((issue_tail && tail_last) ||
					(take && cmd == fc_pkg::CMD_END && tail_n == '0)) begin
				for (int k = 0; k < MAX_TAPS; k++) dl_q[k] <= '0;
			end
			if (take && cmd == fc_pkg::CMD_LOAD) begin
				for (int k = 0; k < MAX_TAPS; k++)
					if (int'(coef_index) == k) coef_q[k] <= value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_sample || issue_tail) prod_s1 <= prod_n;
	end

	a_tail_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		tail_busy |-> !item_ready)
		else $error("word accepted during tail");

	a_tail_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tail_cnt_q) < MAX_TAPS)
		else $error("tail count beyond tap range");

	a_sample_issues: assert property (@(posedge clk) disable iff (!arst_n)
		issue_sample |=> ctl_s1.valid && ctl_s1.last)
		else $error("sample word did not issue a marked result");

	a_tail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		issue_tail && tail_last |=> dl_empty && !tail_busy)
		else $error("delay line not cleared after tail");

endmodule

FILE: hw/rtl/fc_sum.sv
// Two-level registered adder tree and output register with stall handling.
// Depends on fc_pkg; takes the tap products from fc_front.
module fc_sum #(
	parameter int MAX_TAPS     = fc_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_WIDTH = fc_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fc_pkg::op_ctl_t                   ctl_s1,
	input  logic signed [2*SAMPLE_WIDTH-1:0]  prod_s1 [MAX_TAPS],
	output logic                              s2_free,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [fc_pkg::OUT_WIDTH-1:0] filtered_value,
	output logic                              last_of_run
);

	localparam int GROUP = fc_pkg::group_size(MAX_TAPS);
	localparam int LANES = (MAX_TAPS + GROUP - 1) / GROUP;

	fc_pkg::acc_t lane_n  [LANES];
	fc_pkg::acc_t lane_s2 [LANES];
	fc_pkg::acc_t total_n;
	fc_pkg::acc_t filtered_value_q;
	logic         valid_s2, last_s2;
	logic         result_valid_q, last_q;
	logic         adv_out;

	assign adv_out        = !result_valid_q || result_ready;
	assign s2_free        = !valid_s2 || adv_out;
	assign result_valid   = result_valid_q;
	assign filtered_value = filtered_value_q;
	assign last_of_run    = last_q;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			lane_n[j] = '0;
			for (int i = 0; i < GROUP; i++)
				if (j * GROUP + i < MAX_TAPS)
					lane_n[j] = lane_n[j] + fc_pkg::acc_t'(prod_s1[j * GROUP + i]);
		end
	end

	always_comb begin
		total_n = '0;
		for (int j = 0; j < LANES; j++) total_n = total_n + lane_s2[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s2_free) valid_s2 <= ctl_s1.valid;
			if (adv_out) result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && ctl_s1.valid) begin
			lane_s2 <= lane_n;
			last_s2 <= ctl_s1.last;
		end
		if (adv_out && valid_s2) begin
			filtered_value_q <= total_n;
			last_q           <= last_s2;
		end
	end

	a_no_drop_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s2_free |=> valid_s2)
		else $error("second stage word lost under stall");

	a_stall_holds_all: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready && valid_s2 |=> valid_s2 && result_valid_q)
		else $error("pipeline advanced into a stalled output");

endmodule

FILE: sim/tb_fir_convolution.sv
// Self-checking testbench for fir_convolution: random-gap valid/ready driver and
// monitor, APB tap count writes, and a predictor of the convolution sums.
// Depends on fc_pkg and the fir_convolution RTL only.
module tb_fir_convolution;

	localparam int NTAPS  = fc_pkg::DEF_MAX_TAPS;
	localparam int SW     = fc_pkg::DEF_SAMPLE_WIDTH;
	localparam int SETTLE = 12;
	localparam int LIMIT  = 500000;
	localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] MOST_POS = {1'b0, {(SW-1){1'b1}}};

	typedef struct {
		fc_pkg::command_t         cmd;
		logic [fc_pkg::IDX_W-1:0] idx;
		logic signed [SW-1:0]     val;
	} word_t;

	typedef struct {
		logic signed [fc_pkg::OUT_WIDTH-1:0] sum;
		logic                                last;
	} outcome_t;

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [fc_pkg::APB_AW-1:0]           paddr;
	logic [fc_pkg::APB_DW-1:0]           pwdata;
	logic [fc_pkg::APB_DW-1:0]           prdata;
	logic                                pready;
	logic                                item_valid;
	logic                                item_ready;
	logic [fc_pkg::CMD_W-1:0]            command;
	logic [fc_pkg::IDX_W-1:0]            coef_index;
	logic signed [SW-1:0]                value;
	logic                                result_valid;
	logic                                result_ready;
	logic signed [fc_pkg::OUT_WIDTH-1:0] filtered_value;
	logic                                last_of_run;

	word_t    word_queue[$];
	outcome_t pending_sums[$];
	word_t    next_word;
	outcome_t oldest_sum;

	logic signed [SW-1:0]     delay_taps[NTAPS];
	logic signed [SW-1:0]     coef_bank[NTAPS];
	logic [fc_pkg::CFG_W-1:0] tap_reg;

	logic took_item;
	logic took_result;
	logic steady;
	int   send_gap;
	int   stall_left;
	int   issued;
	int   error_count;
	int   cycle_count;

	fir_convolution u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SW-1:0] pick_value();
		unique case ($urandom_range(15))
		0: return MOST_NEG;
		1: return MOST_POS;
		2: return '0;
		3: return '1;
		default: return SW'($urandom);
		endcase
	endfunction

	function automatic int taps_used();
		int t;
		t = int'(tap_reg);
		if (t == 0)
			t = 1;
		if (t > NTAPS)
			t = NTAPS;
		return t;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		$display("%s", msg);
	endtask

	task automatic filter_shift(input logic signed [SW-1:0] sample, input logic last);
		logic signed [fc_pkg::OUT_WIDTH-1:0] acc;
		logic signed [2*SW-1:0]              prod;
		int                                  n;
		n = taps_used();
		for (int k = NTAPS - 1; k > 0; k--)
			delay_taps[k] = delay_taps[k-1];
		delay_taps[0] = sample;
		acc = '0;
		for (int k = 0; k < n; k++) begin
			prod = coef_bank[k] * delay_taps[k];
			acc = acc + prod;
		end
		pending_sums.push_back('{acc, last});
	endtask

	task automatic predict_word(input fc_pkg::command_t cmd,
			input logic [fc_pkg::IDX_W-1:0] idx, input logic signed [SW-1:0] val);
		int tail;
		unique case (cmd)
		fc_pkg::CMD_LOAD: coef_bank[idx] = val;
		fc_pkg::CMD_SAMPLE: filter_shift(val, 1'b1);
		fc_pkg::CMD_END: begin
			tail = taps_used() - 1;
			for (int i = 0; i < tail; i++)
				filter_shift('0, i == tail - 1);
			foreach (delay_taps[k])
				delay_taps[k] = '0;
		end
		default: ;
		endcase
	endtask

	task automatic queue_word(input fc_pkg::command_t cmd, input int idx,
			input logic signed [SW-1:0] val);
		word_queue.push_back('{cmd, fc_pkg::IDX_W'(idx), val});
		if (cmd != fc_pkg::CMD_NONE)
			issued++;
	endtask

	task automatic write_taps(input int count);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= fc_pkg::APB_AW'(4 * int'(fc_pkg::REG_TAP_COUNT));
		pwdata  <= fc_pkg::APB_DW'(count);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tap_reg = fc_pkg::CFG_W'(count);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain();
		while (word_queue.size() > 0 || item_valid || pending_sums.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(input int budget);
		int start;
		int r;
		start  = issued;
		steady = ($urandom_range(3) == 0);
		repeat ($urandom_range(2, 8))
			queue_word(fc_pkg::CMD_LOAD, $urandom_range(NTAPS - 1), pick_value());
		while (issued - start < budget) begin
			r = $urandom_range(99);
			if (r < 70)
				queue_word(fc_pkg::CMD_SAMPLE, $urandom_range(31), pick_value());
			else if (r < 80)
				queue_word(fc_pkg::CMD_END, $urandom_range(31), pick_value());
			else if (r < 93)
				queue_word(fc_pkg::CMD_LOAD, $urandom_range(NTAPS - 1), pick_value());
			else
				queue_word(fc_pkg::CMD_NONE, $urandom_range(31), pick_value());
		end
		queue_word(fc_pkg::CMD_END, $urandom_range(31), pick_value());
	endtask

	// driver: hold the word until taken, then idle for the chosen gap
	always @(negedge clk) begin
		if (arst_n && (!item_valid || took_item)) begin
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				next_word = word_queue.pop_front();
				command    <= next_word.cmd;
				coef_index <= next_word.idx;
				value      <= next_word.val;
				item_valid <= 1'b1;
				send_gap   = pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && (took_result || $urandom_range(7) == 0))
				stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// monitor: predict on each accepted word, compare each accepted result
	always @(posedge clk) begin
		took_item   <= item_valid && item_ready;
		took_result <= result_valid && result_ready;
		if (arst_n) begin
			cycle_count++;
			if (item_valid && item_ready)
				predict_word(fc_pkg::command_t'(command), coef_index, value);
			if (result_valid && result_ready) begin
				if (pending_sums.size() == 0) begin
					note_error($sformatf("cycle %0d: unexpected result %0d last %0b",
						cycle_count, filtered_value, last_of_run));
				end else begin
					oldest_sum = pending_sums.pop_front();
					if (filtered_value !== oldest_sum.sum)
						note_error($sformatf("cycle %0d: filtered_value %0d, want %0d",
							cycle_count, filtered_value, oldest_sum.sum));
					if (last_of_run !== oldest_sum.last)
						note_error($sformatf("cycle %0d: last_of_run %0b, want %0b",
							cycle_count, last_of_run, oldest_sum.last));
				end
			end
			if (cycle_count > LIMIT) begin
				$display("tb_fir_convolution: errors");
				$finish;
			end
		end
	end

	initial begin
		int plan[$];
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		item_valid   = 1'b0;
		command      = '0;
		coef_index   = '0;
		value        = '0;
		result_ready = 1'b0;
		took_item    = 1'b0;
		took_result  = 1'b0;
		steady       = 1'b0;
		send_gap     = 0;
		stall_left   = 0;
		issued       = 0;
		error_count  = 0;
		cycle_count  = 0;
		tap_reg      = fc_pkg::TAP_COUNT_RESET;
		foreach (delay_taps[k]) begin
			delay_taps[k] = '0;
			coef_bank[k]  = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset tap count
		queue_word(fc_pkg::CMD_LOAD, 0, MOST_POS);
		queue_word(fc_pkg::CMD_LOAD, 31, MOST_NEG);
		queue_word(fc_pkg::CMD_LOAD, 1, MOST_NEG);
		queue_word(fc_pkg::CMD_LOAD, 15, SW'(1));
		queue_word(fc_pkg::CMD_SAMPLE, 31, MOST_NEG);
		queue_word(fc_pkg::CMD_SAMPLE, 0, MOST_POS);
		queue_word(fc_pkg::CMD_NONE, 21, 16'h5a5a);
		queue_word(fc_pkg::CMD_SAMPLE, 10, '0);
		queue_word(fc_pkg::CMD_SAMPLE, 21, '1);
		queue_word(fc_pkg::CMD_SAMPLE, 5, SW'(1));
		queue_word(fc_pkg::CMD_END, 31, MOST_NEG);
		queue_word(fc_pkg::CMD_SAMPLE, 0, MOST_POS);
		queue_word(fc_pkg::CMD_LOAD, 31, MOST_POS);
		queue_word(fc_pkg::CMD_SAMPLE, 14, MOST_NEG);
		queue_word(fc_pkg::CMD_END, 0, '0);
		queue_word(fc_pkg::CMD_END, 3, SW'(7));
		drain();

		// full scale both ways
		write_taps(NTAPS);
		for (int k = 0; k < NTAPS; k++)
			queue_word(fc_pkg::CMD_LOAD, k, MOST_NEG);
		repeat (NTAPS) queue_word(fc_pkg::CMD_SAMPLE, $urandom_range(31), MOST_NEG);
		repeat (NTAPS) queue_word(fc_pkg::CMD_SAMPLE, $urandom_range(31), MOST_POS);
		queue_word(fc_pkg::CMD_END, $urandom_range(31), pick_value());
		drain();

		plan = '{1, 0, 63, 2, 31, 33, 16};
		foreach (plan[i]) begin
			write_taps(plan[i]);
			random_phase($urandom_range(8, 16));
			drain();
		end
		while (issued < 240) begin
			write_taps(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(1, NTAPS));
			random_phase($urandom_range(8, 16));
			drain();
		end

		if (error_count == 0)
			$display("tb_fir_convolution: clean");
		else
			$display("tb_fir_convolution: errors");
		$finish;
	end

endmodule
